>>> rtl/ordered_value_list_defines.svh
// Assertion macros shared by the ordered value list RTL.
// Depends on nothing; files that check themselves include it by name.
`ifndef ORDERED_VALUE_LIST_DEFINES_SVH
`define ORDERED_VALUE_LIST_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define OVL_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ordered_value_list check failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define OVL_IMPLY(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("ordered_value_list implication failed");

`endif

>>> rtl/ovl_pkg.sv
// Shared types and codes for the ordered value list.
// Depends on nothing; used by every module of the block.
package ovl_pkg;

  // Fixed widths of the transaction fields.
  localparam int KIND_BITS  = 2;
  localparam int FIELD_BITS = 32;
  localparam int LEN_BITS   = 5;

  // Default sizes for the top-level parameters.
  localparam int DEF_DEPTH      = 16;
  localparam int DEF_VALUE_BITS = 32;

  // Operation codes.
  localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_UPDATE = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd3;

  // Token modes that travel down the cell chain.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_IDLE   = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_SHIFT  = 2'd2;

  // Status that one cell reports to the control logic.
  typedef struct packed {
    logic act;  // the token sits in this cell
    logic hit;  // the operation matched or stored here
    logic fin;  // the token ends here
  } cell_flags_t;

  // One result transaction.
  typedef struct packed {
    logic                hit;
    logic                overflow;
    logic [LEN_BITS-1:0] length;
  } result_t;

endpackage

>>> rtl/ordered_value_list.sv
// Top level of the ordered value list: a chain of list cells plus control.
// Depends on ovl_pkg, ovl_cell, ovl_outbuf and the assertion macro header.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     kind, key, new_value
//   result    out        result_valid / result_stall hit, overflow, length
//
// A search token walks the cell chain one cell per cycle; each cycle the
// cell holding it compares, stores or shifts. An item keeps the chain busy
// while its token visits the cells, and its result is pushed into the
// output buffer in the cycle the token stops. The next item waits until busy
// has cleared. Synchronous reset empties the list at once.
// A stalled result waits in the output register; one more result can wait
// behind it, and items are held off while busy or while that second slot is full.
`include "ordered_value_list_defines.svh"
module ordered_value_list import ovl_pkg::*; #(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [KIND_BITS-1:0]        kind,
  input  logic signed [FIELD_BITS-1:0] key,
  input  logic signed [FIELD_BITS-1:0] new_value,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        hit,
  output logic                        overflow,
  output logic [LEN_BITS-1:0]         length
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  busy;
  logic                  hit_seen;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic [KIND_BITS-1:0]  cmd_kind;
  logic [VALUE_BITS-1:0] cmd_key;
  logic [VALUE_BITS-1:0] cmd_nv;
  logic [VALUE_BITS-1:0] key_v;
  logic [VALUE_BITS-1:0] nv_v;
  logic                  buf_full;
  logic                  hit_now;
  logic                  fin_now;
  logic                  hit_total;
  result_t               res;
  result_t               out_res;

  logic [VALUE_BITS-1:0] val_arr  [DEPTH];
  logic [DEPTH-1:0]      used_vec;
  mode_t                 tok_arr  [DEPTH];
  cell_flags_t           flag_arr [DEPTH];
  logic [DEPTH-1:0]      act_vec;
  logic [DEPTH-1:0]      hit_vec;
  logic [DEPTH-1:0]      fin_vec;

  assign item_stall = busy || buf_full;
  assign accept     = item_valid && !item_stall;

  // Sign-extend or cut the 32-bit fields to the stored value width.
  if (VALUE_BITS <= FIELD_BITS) begin : g_cut
    assign key_v = key[VALUE_BITS-1:0];
    assign nv_v  = new_value[VALUE_BITS-1:0];
  end else begin : g_ext
    assign key_v = {{(VALUE_BITS-FIELD_BITS){key[FIELD_BITS-1]}}, key};
    assign nv_v  = {{(VALUE_BITS-FIELD_BITS){new_value[FIELD_BITS-1]}}, new_value};
  end

  // The transaction is held for the cells while its token walks.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind <= kind;
      cmd_key  <= key_v;
      cmd_nv   <= nv_v;
    end
  end

  // The chain of list cells; the last one sees an empty neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mode_t                 tok_in;
    logic [VALUE_BITS-1:0] nbr_value;
    logic                  nbr_used;

    if (i == 0) begin : g_head
      assign tok_in = accept ? MODE_SEARCH : MODE_IDLE;
    end else begin : g_body
      assign tok_in = tok_arr[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nbr_value = '0;
      assign nbr_used  = 1'b0;
    end else begin : g_link
      assign nbr_value = val_arr[i+1];
      assign nbr_used  = used_vec[i+1];
    end

    ovl_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .kind     (cmd_kind),
      .key      (cmd_key),
      .new_value(cmd_nv),
      .tok_in   (tok_in),
      .nbr_value(nbr_value),
      .nbr_used (nbr_used),
      .value    (val_arr[i]),
      .used     (used_vec[i]),
      .tok_out  (tok_arr[i]),
      .flags    (flag_arr[i])
    );

    assign act_vec[i] = flag_arr[i].act;
    assign hit_vec[i] = flag_arr[i].hit;
    assign fin_vec[i] = flag_arr[i].fin;
  end

  // A token that leaves the last cell found no match and no free slot.
  assign hit_now   = |hit_vec;
  assign fin_now   = (|fin_vec) || (tok_arr[DEPTH-1] != MODE_IDLE);
  assign hit_total = hit_seen || hit_now;

  // Entry count after the finishing transaction.
  always_comb begin
    count_next = count;
    if (fin_now && hit_total) begin
      case (cmd_kind)
        KIND_INSERT: count_next = count + CNT_BITS'(1);
        KIND_REMOVE: count_next = count - CNT_BITS'(1);
        default:     count_next = count;
      endcase
    end
  end

  // Busy from acceptance until the token stops.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      hit_seen <= 1'b0;
      count    <= '0;
    end else begin
      count <= count_next;
      if (accept) begin
        busy     <= 1'b1;
        hit_seen <= 1'b0;
      end else if (fin_now) begin
        busy     <= 1'b0;
        hit_seen <= 1'b0;
      end else if (hit_now) begin
        hit_seen <= 1'b1;
      end
    end
  end

  // Result of the finishing transaction.
  always_comb begin
    res.hit      = hit_total;
    res.overflow = (cmd_kind == KIND_INSERT) && !hit_total;
    res.length   = LEN_BITS'(count_next);
  end

  ovl_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (fin_now),
    .push_data(res),
    .full     (buf_full),
    .out_valid(result_valid),
    .out_stall(result_stall),
    .out_data (out_res)
  );

  assign hit      = out_res.hit;
  assign overflow = out_res.overflow;
  assign length   = out_res.length;

  // Only one token is ever in the chain.
  `OVL_CHECK(a_one_token, $onehot0(act_vec))
  // The chain holds a token exactly while a transaction is in progress.
  `OVL_CHECK(a_busy_token, busy == (|act_vec))
  // The entry count never passes the list size.
  `OVL_CHECK(a_count_bound, count <= CNT_BITS'(DEPTH))

endmodule

>>> rtl/ovl_cell.sv
// One list slot: a stored value, its used bit and the token register.
// Depends on ovl_pkg for operation codes, token modes and the flag struct.
module ovl_cell import ovl_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [KIND_BITS-1:0] kind,
  input  logic [VALUE_BITS-1:0] key,
  input  logic [VALUE_BITS-1:0] new_value,
  input  mode_t                tok_in,
  input  logic [VALUE_BITS-1:0] nbr_value,
  input  logic                 nbr_used,
  output logic [VALUE_BITS-1:0] value,
  output logic                 used,
  output mode_t                tok_out,
  output cell_flags_t          flags
);

  mode_t                 tok;
  logic [VALUE_BITS-1:0] value_next;
  logic                  used_next;
  logic                  match;

  // The token register takes the token that the previous cell passes on.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok  <= MODE_IDLE;
      used <= 1'b0;
    end else begin
      tok  <= tok_in;
      used <= used_next;
    end
  end

  // Stored value needs no reset; unused slots are never compared.
  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign match = used && (value == key);

  // Act on the token: search for a match, store, or pull from the neighbor.
  always_comb begin
    value_next = value;
    used_next  = used;
    tok_out    = MODE_IDLE;
    flags      = '0;
    flags.act  = (tok != MODE_IDLE);
    case (tok)
      MODE_SEARCH: begin
        case (kind)
          KIND_INSERT: begin
            if (!used) begin
              value_next = key;
              used_next  = 1'b1;
              flags.hit  = 1'b1;
              flags.fin  = 1'b1;
            end else begin
              tok_out = MODE_SEARCH;
            end
          end
          KIND_FIND: begin
            if (match) begin
              flags.hit = 1'b1;
              flags.fin = 1'b1;
            end else if (!used) begin
              flags.fin = 1'b1;
            end else begin
              tok_out = MODE_SEARCH;
            end
          end
          KIND_UPDATE: begin
            if (match) begin
              value_next = new_value;
              flags.hit  = 1'b1;
              flags.fin  = 1'b1;
            end else if (!used) begin
              flags.fin = 1'b1;
            end else begin
              tok_out = MODE_SEARCH;
            end
          end
          KIND_REMOVE: begin
            if (match) begin
              // The matched slot takes its neighbor's entry and starts the shift.
              flags.hit  = 1'b1;
              value_next = nbr_value;
              used_next  = nbr_used;
              if (nbr_used) begin
                tok_out = MODE_SHIFT;
              end else begin
                flags.fin = 1'b1;
              end
            end else if (!used) begin
              flags.fin = 1'b1;
            end else begin
              tok_out = MODE_SEARCH;
            end
          end
          default: begin
            flags.fin = 1'b1;
          end
        endcase
      end
      MODE_SHIFT: begin
        // Close the gap left by a removal, one slot per cycle.
        value_next = nbr_value;
        used_next  = nbr_used;
        if (nbr_used) begin
          tok_out = MODE_SHIFT;
        end else begin
          flags.fin = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/ovl_outbuf.sv
// Two-entry result buffer: an output register and one pending slot behind it.
// Depends on ovl_pkg for the result struct and on the assertion macro header.
`include "ordered_value_list_defines.svh"
module ovl_outbuf import ovl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    pend_valid;
  result_t pend_data;
  logic    pop;
  logic    out_take;

  assign pop      = out_valid && !out_stall;
  assign out_take = !out_valid || pop;
  assign full     = pend_valid;

  // Control bits of both slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_take) begin
      out_valid  <= pend_valid || push;
      pend_valid <= pend_valid && push;
    end else if (push) begin
      pend_valid <= 1'b1;
    end
  end

  // Payload moves forward whenever the output register frees up.
  always_ff @(posedge clk) begin
    if (out_take) begin
      if (pend_valid) begin
        out_data <= pend_data;
        if (push) begin
          pend_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      pend_data <= push_data;
    end
  end

  // A new result never lands on an occupied pending slot.
  `OVL_IMPLY(a_no_overrun, push, !pend_valid)
  // The pending slot only fills behind a held output register.
  `OVL_IMPLY(a_pend_behind, pend_valid, out_valid)
  // The pending slot fills only when the output was stalled.
  `OVL_IMPLY(a_fill_cause, $rose(pend_valid), $past(out_valid && out_stall))

endmodule
